// ----- rtl/rii_pkg.sv -----
// Shared types, constants and the breakpoint table of the refractive index interpolator.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package rii_pkg;

   // Table size: entries in use, entries stored, widest legal table.
   localparam int TABLE_ENTRIES = 33;
   localparam int BASE_ENTRIES  = 33;
   localparam int MAX_ENTRIES   = 64;
   localparam int ENT_IDX_W     = $clog2(MAX_ENTRIES);

   // Field widths of the table and of the results.
   localparam int WL_W    = 17;
   localparam int RE_W    = 22;
   localparam int IM_W    = 20;
   localparam int DEN_W   = WL_W + 1;
   localparam int FRAC_W  = 16;
   localparam int Q_W     = 18;
   localparam int QIM_W   = 16;

   // Scaling of table values (units of 1e-6) into Q16 with halves rounded up.
   localparam int HALF    = 500000;
   localparam int MICRO   = 1000000;
   localparam int MICRO_W = 20;

   // Datapath widths.
   localparam int PROD_RE_W = RE_W + WL_W;
   localparam int PROD_IM_W = IM_W + WL_W;
   localparam int NUM_W     = PROD_RE_W + 1;
   localparam int DVD_W     = NUM_W + FRAC_W + 1;
   localparam int DVS_W     = DEN_W + MICRO_W;

   typedef enum logic [1:0] {
      RS_INTERP = 2'd0,
      RS_BELOW  = 2'd1,
      RS_ABOVE  = 2'd2
   } range_status_type;

   // Breakpoint wavelengths in units of 0.0001 um.
   localparam logic [WL_W-1:0] BP_WL [BASE_ENTRIES] = '{
      17'd496,   17'd550,   17'd620,   17'd689,   17'd775,   17'd886,
      17'd1033,  17'd1240,  17'd1305,  17'd1378,  17'd1459,  17'd1550,
      17'd1771,  17'd1907,  17'd2066,  17'd2302,  17'd2652,  17'd2894,
      17'd3303,  17'd3610,  17'd4046,  17'd5460,  17'd10139, 17'd15295,
      17'd18131, 17'd24374, 17'd33026, 17'd35564, 17'd50000, 17'd60000,
      17'd70000, 17'd75000, 17'd75000
   };

   // Real index in units of 1e-6.
   localparam logic [RE_W-1:0] BP_RE [BASE_ENTRIES] = '{
      22'd733000,  22'd822000,  22'd859000,  22'd957000,  22'd1172000,
      22'd1265000, 22'd1475000, 22'd2330000, 22'd2092000, 22'd1904000,
      22'd1702000, 22'd1600000, 22'd1567000, 22'd1543000, 22'd1520000,
      22'd1500000, 22'd1490000, 22'd1480000, 22'd1475000, 22'd1469000,
      22'd1460000, 22'd1455000, 22'd1450000, 22'd1444000, 22'd1440000,
      22'd1430000, 22'd1411000, 22'd1404000, 22'd1342000, 22'd1266000,
      22'd1093000, 22'd902500,  22'd902500
   };

   // Extinction coefficient in units of 1e-6.
   localparam logic [IM_W-1:0] BP_IM [BASE_ENTRIES] = '{
      20'd325000, 20'd408000, 20'd585000, 20'd717000, 20'd808000,
      20'd861000, 20'd323000, 20'd56000,  20'd18900,  20'd5570,
      20'd32,     20'd0,      20'd0,      20'd0,      20'd0,
      20'd0,      20'd0,      20'd0,      20'd0,      20'd0,
      20'd0,      20'd0,      20'd0,      20'd0,      20'd0,
      20'd0,      20'd0,      20'd0,      20'd0,      20'd0,
      20'd0,      20'd0,      20'd0
   };

   // Entries past the stored table repeat the last stored entry.
   function automatic logic [ENT_IDX_W-1:0] ent_clamp(input logic [ENT_IDX_W-1:0] k);
      logic [ENT_IDX_W-1:0] top_idx;
      top_idx = ENT_IDX_W'(BASE_ENTRIES - 1);
      return (k > top_idx) ? top_idx : k;
   endfunction

   function automatic logic [WL_W-1:0] entry_wl(input logic [ENT_IDX_W-1:0] k);
      return BP_WL[ent_clamp(k)];
   endfunction

   function automatic logic [RE_W-1:0] entry_re(input logic [ENT_IDX_W-1:0] k);
      return BP_RE[ent_clamp(k)];
   endfunction

   function automatic logic [IM_W-1:0] entry_im(input logic [ENT_IDX_W-1:0] k);
      return BP_IM[ent_clamp(k)];
   endfunction

   // Segment found for one wavelength.
   typedef struct packed {
      logic [WL_W-1:0]      x;
      logic [ENT_IDX_W-1:0] seg;
      range_status_type     status;
   } locate_type;

   // End points and distances of the chosen segment.
   typedef struct packed {
      logic [RE_W-1:0]  a_re;
      logic [RE_W-1:0]  b_re;
      logic [IM_W-1:0]  a_im;
      logic [IM_W-1:0]  b_im;
      logic [WL_W-1:0]  d1;
      logic [WL_W-1:0]  d2;
      logic [DEN_W-1:0] den;
      range_status_type status;
   } opnd_type;

   // Partial products and the scaled segment width.
   typedef struct packed {
      logic [PROD_RE_W-1:0] p_are;
      logic [PROD_RE_W-1:0] p_bre;
      logic [PROD_IM_W-1:0] p_aim;
      logic [PROD_IM_W-1:0] p_bim;
      logic [DVS_W-1:0]     half;
      logic [DVS_W-1:0]     dvs;
      range_status_type     status;
   } prod_type;

   // Divider state: partial remainders, and registers that shift dividend bits
   // out at the top while quotient bits enter at the bottom.
   typedef struct packed {
      logic [DVS_W-1:0] rem_re;
      logic [DVS_W-1:0] rem_im;
      logic [Q_W-1:0]   acc_re;
      logic [Q_W-1:0]   acc_im;
      logic [DVS_W-1:0] dvs;
      range_status_type status;
   } div_type;

endpackage

`default_nettype wire

// ----- rtl/rii_locate.sv -----
// Segment search and operand selection: two pipeline stages of the interpolator.
// Depends on rii_pkg for the breakpoint table and the stage types.
`default_nettype none

module rii_locate (
   input  wire                          clock,
   input  wire                          en,
   input  wire logic [rii_pkg::WL_W-1:0] x,
   output rii_pkg::opnd_type             opnd
);
   import rii_pkg::*;

   locate_type loc_ff, loc_in;
   opnd_type   opnd_ff, opnd_in;

   // Range check and binary search for the first segment whose right end
   // is not below the wavelength.
   always_comb begin
      logic [ENT_IDX_W-1:0] pos;
      logic [ENT_IDX_W-1:0] cand;
      logic [ENT_IDX_W-1:0] seg_max;
      pos     = '0;
      seg_max = ENT_IDX_W'(TABLE_ENTRIES - 2);
      for (int s = ENT_IDX_W - 1; s >= 0; s--) begin
         cand = pos | ENT_IDX_W'(1 << s);
         if ((cand <= ENT_IDX_W'(TABLE_ENTRIES - 1)) && (entry_wl(cand) < x)) begin
            pos = cand;
         end
      end
      loc_in.x   = x;
      loc_in.seg = (pos > seg_max) ? seg_max : pos;
      if (x < entry_wl('0)) begin
         loc_in.status = RS_BELOW;
      end else if (x > entry_wl(ENT_IDX_W'(TABLE_ENTRIES - 1))) begin
         loc_in.status = RS_ABOVE;
      end else begin
         loc_in.status = RS_INTERP;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         loc_ff <= loc_in;
      end
   end

   // Pick both end entries and the distances. A clamped result or a
   // zero-width segment reduces to the left entry over a width of one.
   always_comb begin
      logic [ENT_IDX_W-1:0] ia;
      logic [ENT_IDX_W-1:0] ib;
      logic [WL_W-1:0]      a_wl;
      logic [WL_W-1:0]      b_wl;
      logic [WL_W-1:0]      d1;
      logic [WL_W-1:0]      d2;
      logic [DEN_W-1:0]     den;
      ia = loc_ff.seg;
      ib = loc_ff.seg + ENT_IDX_W'(1);
      if (loc_ff.status == RS_BELOW) begin
         ia = '0;
         ib = '0;
      end else if (loc_ff.status == RS_ABOVE) begin
         ia = ENT_IDX_W'(TABLE_ENTRIES - 1);
         ib = ENT_IDX_W'(TABLE_ENTRIES - 1);
      end
      a_wl = entry_wl(ia);
      b_wl = entry_wl(ib);
      d1   = (loc_ff.x >= a_wl) ? (loc_ff.x - a_wl) : '0;
      d2   = (b_wl >= loc_ff.x) ? (b_wl - loc_ff.x) : '0;
      den  = {1'b0, d1} + {1'b0, d2};
      if ((loc_ff.status != RS_INTERP) || (den == '0)) begin
         d1  = '0;
         d2  = WL_W'(1);
         den = DEN_W'(1);
      end
      opnd_in.a_re   = entry_re(ia);
      opnd_in.b_re   = entry_re(ib);
      opnd_in.a_im   = entry_im(ia);
      opnd_in.b_im   = entry_im(ib);
      opnd_in.d1     = d1;
      opnd_in.d2     = d2;
      opnd_in.den    = den;
      opnd_in.status = loc_ff.status;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opnd_ff <= opnd_in;
      end
   end

   assign opnd = opnd_ff;

endmodule

`default_nettype wire

// ----- rtl/rii_product.sv -----
// Weighted sums of the interpolator: a multiply stage and a sum stage that
// forms the dividend and divisor. Depends on rii_pkg.
`default_nettype none

module rii_product (
   input  wire               clock,
   input  wire               en,
   input  rii_pkg::opnd_type opnd,
   output rii_pkg::div_type  dstart
);
   import rii_pkg::*;

   prod_type prod_ff, prod_in;
   div_type  dstart_ff, dstart_in;

   // Four weight products, plus the rounding offset and divisor from the width.
   always_comb begin
      prod_in.p_are  = PROD_RE_W'(opnd.a_re) * PROD_RE_W'(opnd.d2);
      prod_in.p_bre  = PROD_RE_W'(opnd.b_re) * PROD_RE_W'(opnd.d1);
      prod_in.p_aim  = PROD_IM_W'(opnd.a_im) * PROD_IM_W'(opnd.d2);
      prod_in.p_bim  = PROD_IM_W'(opnd.b_im) * PROD_IM_W'(opnd.d1);
      prod_in.half   = DVS_W'(opnd.den) * DVS_W'(HALF);
      prod_in.dvs    = DVS_W'(opnd.den) * DVS_W'(MICRO);
      prod_in.status = opnd.status;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

   // Dividend = numerator * 2^16 + rounding offset, split into the starting
   // remainder (upper bits) and the bits still to shift in (lower bits).
   always_comb begin
      logic [NUM_W-1:0] num_re;
      logic [NUM_W-1:0] num_im;
      logic [DVD_W-1:0] dvd_re;
      logic [DVD_W-1:0] dvd_im;
      num_re = NUM_W'(prod_ff.p_are) + NUM_W'(prod_ff.p_bre);
      num_im = NUM_W'(prod_ff.p_aim) + NUM_W'(prod_ff.p_bim);
      dvd_re = DVD_W'({num_re, FRAC_W'(0)}) + DVD_W'(prod_ff.half);
      dvd_im = DVD_W'({num_im, FRAC_W'(0)}) + DVD_W'(prod_ff.half);
      dstart_in.rem_re = DVS_W'(dvd_re[DVD_W-1:Q_W]);
      dstart_in.rem_im = DVS_W'(dvd_im[DVD_W-1:Q_W]);
      dstart_in.acc_re = dvd_re[Q_W-1:0];
      dstart_in.acc_im = dvd_im[Q_W-1:0];
      dstart_in.dvs    = prod_ff.dvs;
      dstart_in.status = prod_ff.status;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dstart_ff <= dstart_in;
      end
   end

   assign dstart = dstart_ff;

endmodule

`default_nettype wire

// ----- rtl/rii_div_step.sv -----
// One restoring-division stage: one quotient bit for each index part.
// Depends on rii_pkg for the divider state type.
`default_nettype none

module rii_div_step (
   input  wire              clock,
   input  wire              en,
   input  rii_pkg::div_type din,
   output rii_pkg::div_type dout
);
   import rii_pkg::*;

   div_type step_ff, step_in;

   // Shift the next dividend bit into each remainder and subtract where it fits.
   always_comb begin
      logic [DVS_W:0] t_re;
      logic [DVS_W:0] t_im;
      logic           ge_re;
      logic           ge_im;
      t_re  = {din.rem_re, din.acc_re[Q_W-1]};
      t_im  = {din.rem_im, din.acc_im[Q_W-1]};
      ge_re = (t_re >= {1'b0, din.dvs});
      ge_im = (t_im >= {1'b0, din.dvs});
      if (ge_re) begin
         t_re = t_re - {1'b0, din.dvs};
      end
      if (ge_im) begin
         t_im = t_im - {1'b0, din.dvs};
      end
      step_in.rem_re = t_re[DVS_W-1:0];
      step_in.rem_im = t_im[DVS_W-1:0];
      step_in.acc_re = {din.acc_re[Q_W-2:0], ge_re};
      step_in.acc_im = {din.acc_im[Q_W-2:0], ge_im};
      step_in.dvs    = din.dvs;
      step_in.status = din.status;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign dout = step_ff;

endmodule

`default_nettype wire

// ----- rtl/refractive_index_interpolator_core.sv -----
// Top level of the refractive index interpolator: input register, pipeline
// valid bits, divider chain, output register and skid entry.
// Depends on rii_pkg, rii_locate, rii_product and rii_div_step.
//
//   Channel  Direction  Contents
//   req_*    in         wavelength, one per transfer
//   rsp_*    out        index_real, index_imag (tdata); range_status (tuser)
//
// One item enters per cycle while the skid entry is empty. Each result passes
// through the input register, two search stages, two product stages and
// the 18 stages of the bit-per-stage divider, then the output register.
// Reset clears all valid bits; payload registers are not reset.
// The pipeline moves as one while the skid entry is empty; a stalled result
// waits in the output register while one more lands in the skid entry.
`default_nettype none

module refractive_index_interpolator_core (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire [23:0] req_tdata,   // [16:0] wavelength
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [39:0] rsp_tdata,  // [17:0] index_real, [33:18] index_imag
   output logic [1:0] rsp_tuser    // [1:0] range_status
);
   import rii_pkg::*;

   localparam int NUM_STG    = 5 + Q_W;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic [Q_W-1:0]   re;
      logic [QIM_W-1:0] im;
      range_status_type status;
   } result_type;

   logic             en;
   logic [NUM_STG-1:0] v_ff, v_in;
   logic [WL_W-1:0]  x_ff;
   opnd_type         opnd;
   div_type          chain [Q_W+1];
   result_type       fin;
   result_type       out_ff, out_in, skid_ff, skid_in;
   logic             out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   logic             push, take;

   // The whole pipeline advances while the skid entry is free.
   assign en         = !skid_v_ff;
   assign req_tready = en;

   // Valid bits travel with the stages.
   always_comb begin
      v_in = v_ff;
      if (en) begin
         v_in = {v_ff[NUM_STG-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= req_tdata[WL_W-1:0];
      end
   end

   rii_locate u_locate (
      .clock (clock),
      .en    (en),
      .x     (x_ff),
      .opnd  (opnd)
   );

   rii_product u_product (
      .clock  (clock),
      .en     (en),
      .opnd   (opnd),
      .dstart (chain[0])
   );

   // Divider chain, one quotient bit per stage.
   for (genvar j = 0; j < Q_W; j++) begin : g_div
      rii_div_step u_step (
         .clock (clock),
         .en    (en),
         .din   (chain[j]),
         .dout  (chain[j+1])
      );
   end

   assign fin.re     = chain[Q_W].acc_re;
   assign fin.im     = chain[Q_W].acc_im[QIM_W-1:0];
   assign fin.status = chain[Q_W].status;

   // Output register with one skid entry behind it.
   assign push = en && v_ff[NUM_STG-1];
   assign take = out_v_ff && rsp_tready;

   always_comb begin
      out_in    = out_ff;
      out_v_in  = out_v_ff;
      skid_in   = skid_ff;
      skid_v_in = skid_v_ff;
      if (skid_v_ff) begin
         if (take) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end
      end else if (push) begin
         if (!out_v_ff || take) begin
            out_in   = fin;
            out_v_in = 1'b1;
         end else begin
            skid_in   = fin;
            skid_v_in = 1'b1;
         end
      end else if (take) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   // Result transfer.
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {(RSP_DATA_W - Q_W - QIM_W)'(0), out_ff.im, out_ff.re};
   assign rsp_tuser  = out_ff.status;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for refractive_index_interpolator_core: wavelength transfers go in,
// and each result is compared with an interpolator that runs over a local copy of the table.
// Depends on rii_pkg (range_status_type) and the core RTL.
module tb_top;
   import rii_pkg::*;

   localparam int LUT_SIZE     = 33;
   localparam int MAX_REPORTS  = 10;
   localparam int PHASE_ITEMS  = 440;
   localparam int HOLD_CYCLES  = 200;
   localparam int TAIL_CYCLES  = 40;
   localparam longint unsigned MICRO_UNITS = 1000000;

   // Breakpoints: wavelength in 0.0001 um, both index parts in 1e-6 units.
   localparam int unsigned LUT_WL [LUT_SIZE] = '{
      496, 550, 620, 689, 775, 886, 1033, 1240, 1305, 1378, 1459, 1550, 1771,
      1907, 2066, 2302, 2652, 2894, 3303, 3610, 4046, 5460, 10139, 15295,
      18131, 24374, 33026, 35564, 50000, 60000, 70000, 75000, 75000
   };
   localparam int unsigned LUT_RE [LUT_SIZE] = '{
      733000, 822000, 859000, 957000, 1172000, 1265000, 1475000, 2330000,
      2092000, 1904000, 1702000, 1600000, 1567000, 1543000, 1520000, 1500000,
      1490000, 1480000, 1475000, 1469000, 1460000, 1455000, 1450000, 1444000,
      1440000, 1430000, 1411000, 1404000, 1342000, 1266000, 1093000, 902500,
      902500
   };
   localparam int unsigned LUT_IM [LUT_SIZE] = '{
      325000, 408000, 585000, 717000, 808000, 861000, 323000, 56000, 18900,
      5570, 32, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0
   };

   // Directed wavelengths: below the table, its first and last entries, breakpoints
   // and their neighbors, the top of the field.
   localparam logic [16:0] EDGE_WL [24] = '{
      17'd0, 17'd1, 17'd495, 17'd496, 17'd497, 17'd523, 17'd550, 17'd620,
      17'd1240, 17'd1241, 17'd1304, 17'd1459, 17'd1460, 17'd1550, 17'd4046,
      17'd33026, 17'd65535, 17'd65536, 17'd69999, 17'd70000, 17'd74999,
      17'd75000, 17'd75001, 17'd131071
   };

   typedef struct {
      logic [16:0]      wavelength;
      logic [17:0]      index_real;
      logic [15:0]      index_imag;
      range_status_type status;
   } index_result_type;

   // Holds the predicted index for every accepted wavelength and checks results in order.
   class index_scoreboard;
      index_result_type expected_q[$];
      int mismatches;
      int lookups;
      int results;
      int status_seen [4];

      // Round num / (den * 1e6) to Q16, halves up.
      function longint unsigned to_q16(longint unsigned num, longint unsigned den);
         return (num * 65536 + den * (MICRO_UNITS / 2)) / (den * MICRO_UNITS);
      endfunction

      function index_result_type interpolate(logic [16:0] x);
         index_result_type r;
         int seg;
         longint unsigned d1, d2, den, num_re, num_im;
         r.wavelength = x;
         seg = LUT_SIZE - 2;
         if (x < LUT_WL[0]) begin
            r.status = RS_BELOW;
            num_re = LUT_RE[0];
            num_im = LUT_IM[0];
            den = 1;
         end else if (x > LUT_WL[LUT_SIZE-1]) begin
            r.status = RS_ABOVE;
            num_re = LUT_RE[LUT_SIZE-1];
            num_im = LUT_IM[LUT_SIZE-1];
            den = 1;
         end else begin
            r.status = RS_INTERP;
            // Scan downward so the lowest containing segment wins on a breakpoint.
            for (int i = LUT_SIZE - 2; i >= 0; i--) begin
               if (x >= LUT_WL[i] && x <= LUT_WL[i+1])
                  seg = i;
            end
            d1 = (x >= LUT_WL[seg]) ? x - LUT_WL[seg] : 0;
            d2 = (LUT_WL[seg+1] >= x) ? LUT_WL[seg+1] - x : 0;
            den = d1 + d2;
            if (den == 0) begin
               // A zero-width segment takes its left entry.
               num_re = LUT_RE[seg];
               num_im = LUT_IM[seg];
               den = 1;
            end else begin
               num_re = LUT_RE[seg] * d2 + LUT_RE[seg+1] * d1;
               num_im = LUT_IM[seg] * d2 + LUT_IM[seg+1] * d1;
            end
         end
         r.index_real = 18'(to_q16(num_re, den));
         r.index_imag = 16'(to_q16(num_im, den));
         return r;
      endfunction

      function void flag(string what);
         if (mismatches < MAX_REPORTS)
            $display("ERROR at %0t: %s", $realtime, what);
         mismatches++;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function void note_wavelength(logic [16:0] x);
         expected_q.push_back(interpolate(x));
         lookups++;
      endfunction

      function void check_result(logic [17:0] re, logic [15:0] im, logic [1:0] st);
         index_result_type e;
         results++;
         status_seen[st]++;
         if (expected_q.size() == 0) begin
            flag($sformatf("result real %0d imag %0d status %0d with none pending",
                           re, im, st));
            return;
         end
         e = expected_q.pop_front();
         if (re !== e.index_real || im !== e.index_imag || st !== e.status)
            flag($sformatf({"wavelength %0d: expected real %0d imag %0d status %0d, ",
                            "got %0d %0d %0d"},
                           e.wavelength, e.index_real, e.index_imag, e.status, re, im, st));
      endfunction

      function void close_out();
         if (expected_q.size() != 0)
            flag($sformatf("%0d expected results never arrived", expected_q.size()));
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [23:0] req_tdata = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        hold_rsp = 1'b0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   index_scoreboard sb = new;

   refractive_index_interpolator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Receiver: random stalls, or a forced hold-off while hold_rsp is set.
   always @(posedge clock) begin
      rsp_tready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
   end

   // Every result transfer is checked against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[17:0], rsp_tdata[33:18], rsp_tuser);
   end

   // Offers one wavelength after a random gap and returns once it is transferred.
   // Valid stays high on return so back-to-back items never drop it.
   task automatic send_wavelength(input logic [16:0] wl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, wl};
      do @(posedge clock); while (!req_tready);
      sb.note_wavelength(wl);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // Mostly in-table wavelengths, then breakpoint neighborhoods, then out-of-range values.
   task automatic run_random_phase(input int count, input int idle, input int stall);
      int pick;
      int k;
      logic [16:0] wl;
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) begin
         pick = $urandom_range(99);
         k = $urandom_range(LUT_SIZE - 1);
         if (pick < 70)
            wl = 17'($urandom_range(LUT_WL[LUT_SIZE-1], LUT_WL[0]));
         else if (pick < 85)
            wl = 17'(LUT_WL[k] + $urandom_range(2) - 1);
         else if (pick < 92)
            wl = 17'($urandom_range(LUT_WL[0] - 1));
         else
            wl = 17'($urandom_range(17'h1FFFF, LUT_WL[LUT_SIZE-1] + 1));
         send_wavelength(wl);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed corners with no idling on either side.
      foreach (EDGE_WL[i])
         send_wavelength(EDGE_WL[i]);
      wait_for_results();

      // Receiver holds off long enough to back the pipeline up into the input.
      fork
         begin
            hold_rsp <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp <= 1'b0;
         end
      join_none
      run_random_phase(PHASE_ITEMS, 0, 0);
      wait_for_results();

      run_random_phase(PHASE_ITEMS, 59, 0);
      run_random_phase(PHASE_ITEMS, 0, 59);
      wait_for_results();
      run_random_phase(PHASE_ITEMS, 8, 8);

      // Drain, then allow a full pipeline depth for anything unexpected.
      wait_for_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.close_out();
      $display("Checked %0d wavelength lookups against %0d results over five idle/stall phases.",
               sb.lookups, sb.results);
      $display("Status mix: %0d interpolated, %0d clamped below, %0d clamped above; %0d errors.",
               sb.status_seen[RS_INTERP], sb.status_seen[RS_BELOW],
               sb.status_seen[RS_ABOVE], sb.mismatches);
      if (sb.mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("Timeout: %0d results still outstanding.", sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
